FILE: rtl/core/cgw_pkg.sv
// ----------------------------------------------------------------------------
// cgw_pkg
// Shared types, character codes and widths of the CIGAR gap walker.
// ----------------------------------------------------------------------------
`default_nettype none

package cgw_pkg;

  // Default width of the walk counters and the length accumulator
  localparam int POS_BITS_DEFAULT = 32;

  // Fixed field widths
  localparam int SYM_W       = 8;
  localparam int OUT_W       = 32;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (2 * OUT_W + 2 + 1);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // ASCII codes
  localparam logic [SYM_W-1:0] CH_0  = 8'h30;
  localparam logic [SYM_W-1:0] CH_9  = 8'h39;
  localparam logic [SYM_W-1:0] CH_M  = 8'h4D;
  localparam logic [SYM_W-1:0] CH_X  = 8'h58;
  localparam logic [SYM_W-1:0] CH_EQ = 8'h3D;
  localparam logic [SYM_W-1:0] CH_I  = 8'h49;
  localparam logic [SYM_W-1:0] CH_D  = 8'h44;
  localparam logic [SYM_W-1:0] CH_N  = 8'h4E;
  localparam logic [SYM_W-1:0] CH_S  = 8'h53;
  localparam logic [SYM_W-1:0] CH_P  = 8'h50;
  localparam logic [SYM_W-1:0] CH_H  = 8'h48;

  typedef enum logic [1:0] {
    KIND_END  = 2'd0,
    KIND_TGT  = 2'd1,
    KIND_DEL  = 2'd2,
    KIND_SKIP = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_SYNTAX = 2'd1,
    ST_TGT    = 2'd2,
    ST_REF    = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REVERSE    = 3'd0,
    CFG_REF_LEN    = 3'd1,
    CFG_SPAN_START = 3'd2,
    CFG_SPAN_END   = 3'd3,
    CFG_TGT_LEN    = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_DIGIT  = 3'd0,
    OP_ALIGN  = 3'd1,
    OP_IGNORE = 3'd2,
    OP_CLIP   = 3'd3,
    OP_INS    = 3'd4,
    OP_DEL    = 3'd5,
    OP_SKIP   = 3'd6,
    OP_BAD    = 3'd7
  } op_t;

  // Control part of one queue entry
  typedef struct packed {
    logic    has_gap;
    logic    has_end;
    kind_t   kind;
    status_t status;
    logic    clip;
  } entry_ctl_t;

  function automatic op_t classify(logic [SYM_W-1:0] sym);
    op_t op;
    if (sym >= CH_0 && sym <= CH_9) begin
      op = OP_DIGIT;
    end else begin
      unique case (sym)
        CH_M, CH_X, CH_EQ: op = OP_ALIGN;
        CH_P, CH_H:        op = OP_IGNORE;
        CH_S:              op = OP_CLIP;
        CH_I:              op = OP_INS;
        CH_D:              op = OP_DEL;
        CH_N:              op = OP_SKIP;
        default:           op = OP_BAD;
      endcase
    end
    return op;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cigar_gap_walker_unit.sv
// ----------------------------------------------------------------------------
// cigar_gap_walker_unit
// CIGAR string walker that reports insertion, deletion and skip gaps.
// ----------------------------------------------------------------------------
// The block reads a CIGAR string one ASCII character per beat on the slave
// stream (s_tlast marks the final character) and writes one record per beat
// on the master stream. Digits build an operation length that saturates at
// all ones; M, X and = advance both walk counters, S advances the query
// counter and raises the clip warning, P and H are skipped, and I, D and N
// each produce a gap record whose position is mirrored for the reverse
// strand. The final character closes the string with an end status record
// (syntax error, target span mismatch, reference span mismatch, or ok) and
// clears the walk. A final character that is also a gap letter gives two
// records, the gap first. Input takes one character every cycle while the
// queue has room; the output register moves one record per cycle while
// m_tready is high, so the two records of a final gap letter are absorbed by
// the two-entry queue between the character front end and the record
// emitter. With the output free, the first record of an accepted character
// passes through a queue entry, then the output register, to m_tvalid.
// Write configuration only while no string is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module cigar_gap_walker_unit import cgw_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // character stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] symbol
  input  logic                   s_tlast,   // final_symbol
  // record stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] gap_position, [63:32] gap_length,
                                            // [65:64] end_status, [66] clip_warning,
                                            // [71:67] zero
  output logic [1:0]             m_tuser,   // [1:0] record_kind
  output logic                   m_tlast,   // last_of_run
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int DATA_W = 2 * POS_BITS;

  // Configuration registers
  logic             reverse;
  logic [CFG_W-1:0] ref_len;
  logic [CFG_W-1:0] span_start;
  logic [CFG_W-1:0] span_end;
  logic [CFG_W-1:0] tgt_len;

  // Front to queue
  logic              push;
  entry_ctl_t        push_ctl;
  logic [DATA_W-1:0] push_data;
  logic              q_full;

  // Queue to back
  logic              head_valid;
  entry_ctl_t        head_ctl;
  logic [DATA_W-1:0] head_data;
  logic              pop;

  // Always ready for a register write; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reverse    <= 1'b0;
      ref_len    <= '0;
      span_start <= '0;
      span_end   <= '0;
      tgt_len    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_REVERSE:    reverse    <= cfg_data[0];
        CFG_REF_LEN:    ref_len    <= cfg_data;
        CFG_SPAN_START: span_start <= cfg_data;
        CFG_SPAN_END:   span_end   <= cfg_data;
        CFG_TGT_LEN:    tgt_len    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: classify each character, advance the walk, request records
  cgw_front #(
    .POS_BITS (POS_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .sym        (s_tdata[SYM_W-1:0]),
    .fin        (s_tlast),
    .reverse    (reverse),
    .ref_len    (ref_len),
    .span_start (span_start),
    .span_end   (span_end),
    .tgt_len    (tgt_len),
    .q_full     (q_full),
    .push       (push),
    .push_ctl   (push_ctl),
    .push_data  (push_data)
  );

  // Hold requests while the output side stalls
  cgw_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ctl   (push_ctl),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_ctl   (head_ctl),
    .head_data  (head_data),
    .full       (q_full)
  );

  // Back: mirror positions and drive the record stream
  cgw_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_ctl   (head_ctl),
    .head_data  (head_data),
    .pop        (pop),
    .reverse    (reverse),
    .ref_len    (ref_len),
    .tgt_len    (tgt_len),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_kind   (m_tuser),
    .out_last   (m_tlast)
  );

  // An end status beat always closes the run
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_END) |-> m_tlast)
    else $error("end status beat without tlast");

  // Gap beats carry no status
  a_gap_status_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != KIND_END) |-> (m_tdata[2*OUT_W+1:2*OUT_W] == ST_OK))
    else $error("gap beat with nonzero end status");

  // Input backpressure only while a record is waiting at the output
  a_stall_only_on_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output register");

  // Queue never drains without a record going out
  a_pop_loads_output: assert property (@(posedge clk) disable iff (rst)
    pop |=> m_tvalid)
    else $error("queue entry retired without an output beat");

endmodule

`default_nettype wire

FILE: rtl/core/cgw_front.sv
// ----------------------------------------------------------------------------
// cgw_front
// Character intake: length accumulation, walk counters, record requests.
// ----------------------------------------------------------------------------
`default_nettype none

module cgw_front import cgw_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SYM_W-1:0]      sym,
  input  logic                  fin,
  input  logic                  reverse,
  input  logic [CFG_W-1:0]      ref_len,
  input  logic [CFG_W-1:0]      span_start,
  input  logic [CFG_W-1:0]      span_end,
  input  logic [CFG_W-1:0]      tgt_len,
  input  logic                  q_full,
  output logic                  push,
  output entry_ctl_t            push_ctl,
  output logic [2*POS_BITS-1:0] push_data
);

  localparam int WIDE_W = POS_BITS + 4;

  logic [POS_BITS-1:0] q_adv, q_adv_next;
  logic [POS_BITS-1:0] t_adv, t_adv_next;
  logic [POS_BITS-1:0] acc, acc_next;
  logic                digit_seen, digit_seen_next;
  logic                err, err_next;
  logic                clip, clip_next;

  // Config-derived terms
  logic [POS_BITS-1:0] ref_offs;
  logic [POS_BITS-1:0] span_diff;
  logic [POS_BITS-1:0] tgt_len_p;

  op_t                 op;
  logic [WIDE_W-1:0]   acc_wide;
  logic [WIDE_W-1:0]   acc_mul;
  logic                gap;
  kind_t               gap_kind;
  logic [POS_BITS-1:0] gap_base;
  status_t             status;
  logic                accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign op       = classify(sym);
  assign acc_wide = {4'b0, acc};
  assign acc_mul  = (acc_wide << 3) + (acc_wide << 1) + WIDE_W'(sym[3:0]);
  assign tgt_len_p = POS_BITS'(tgt_len);

  assign ref_offs  = reverse ? POS_BITS'(ref_len) - POS_BITS'(span_end)
                             : POS_BITS'(span_start);
  assign span_diff = POS_BITS'(span_end) - POS_BITS'(span_start);

  always_comb begin
    q_adv_next      = q_adv;
    t_adv_next      = t_adv;
    acc_next        = acc;
    digit_seen_next = digit_seen;
    err_next        = err;
    clip_next       = clip;
    gap             = 1'b0;
    gap_kind        = KIND_TGT;
    gap_base        = t_adv;
    if (!err) begin
      if (op == OP_DIGIT) begin
        acc_next        = (|acc_mul[WIDE_W-1:POS_BITS]) ? '1 : acc_mul[POS_BITS-1:0];
        digit_seen_next = 1'b1;
      end else if (!digit_seen) begin
        err_next = 1'b1;
      end else begin
        unique case (op)
          OP_ALIGN: begin
            q_adv_next = q_adv + acc;
            t_adv_next = t_adv + acc;
          end
          OP_CLIP: begin
            q_adv_next = q_adv + acc;
            clip_next  = 1'b1;
          end
          OP_INS: begin
            gap        = 1'b1;
            gap_kind   = KIND_TGT;
            gap_base   = t_adv;
            q_adv_next = q_adv + acc;
          end
          OP_DEL, OP_SKIP: begin
            gap        = 1'b1;
            gap_kind   = (op == OP_DEL) ? KIND_DEL : KIND_SKIP;
            gap_base   = ref_offs + q_adv;
            t_adv_next = t_adv + acc;
          end
          OP_BAD: begin
            err_next = 1'b1;
          end
          default: begin
          end
        endcase
        acc_next        = '0;
        digit_seen_next = 1'b0;
      end
    end
  end

  always_comb begin
    priority if (err_next || digit_seen_next) begin
      status = ST_SYNTAX;
    end else if (t_adv_next != tgt_len_p) begin
      status = ST_TGT;
    end else if (q_adv_next != span_diff) begin
      status = ST_REF;
    end else begin
      status = ST_OK;
    end
  end

  assign push             = accept && (gap || fin);
  assign push_ctl.has_gap = gap;
  assign push_ctl.has_end = fin;
  assign push_ctl.kind    = gap_kind;
  assign push_ctl.status  = status;
  assign push_ctl.clip    = clip_next;
  assign push_data        = {acc, gap_base};

  always_ff @(posedge clk) begin
    if (rst) begin
      q_adv      <= '0;
      t_adv      <= '0;
      acc        <= '0;
      digit_seen <= 1'b0;
      err        <= 1'b0;
      clip       <= 1'b0;
    end else if (accept) begin
      if (fin) begin
        q_adv      <= '0;
        t_adv      <= '0;
        acc        <= '0;
        digit_seen <= 1'b0;
        err        <= 1'b0;
        clip       <= 1'b0;
      end else begin
        q_adv      <= q_adv_next;
        t_adv      <= t_adv_next;
        acc        <= acc_next;
        digit_seen <= digit_seen_next;
        err        <= err_next;
        clip       <= clip_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cgw_queue.sv
// ----------------------------------------------------------------------------
// cgw_queue
// Two-entry queue of record requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module cgw_queue import cgw_pkg::*; #(
  parameter int DATA_W = 2 * POS_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  entry_ctl_t        push_ctl,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic              head_valid,
  output entry_ctl_t        head_ctl,
  output logic [DATA_W-1:0] head_data,
  output logic              full
);

  entry_ctl_t        ctl_mem  [QUEUE_DEPTH];
  logic [DATA_W-1:0] data_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head_valid = (count != '0);
  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_ctl   = ctl_mem[rd_ptr];
  assign head_data  = data_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem[wr_ptr]  <= push_ctl;
      data_mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cgw_back.sv
// ----------------------------------------------------------------------------
// cgw_back
// Record emitter: strand mirroring of gap positions and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cgw_back import cgw_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  entry_ctl_t             head_ctl,
  input  logic [2*POS_BITS-1:0]  head_data,
  output logic                   pop,
  input  logic                   reverse,
  input  logic [CFG_W-1:0]       ref_len,
  input  logic [CFG_W-1:0]       tgt_len,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data,
  output logic [1:0]             out_kind,
  output logic                   out_last
);

  logic                phase;
  logic                load;
  logic                emit_gap;
  logic [POS_BITS-1:0] base;
  logic [POS_BITS-1:0] len;
  logic [POS_BITS-1:0] mirror;
  logic [POS_BITS-1:0] pos;
  logic [OUT_W-1:0]    beat_pos;
  logic [OUT_W-1:0]    beat_len;
  status_t             beat_status;
  kind_t               beat_kind;
  logic                beat_last;

  assign base     = head_data[POS_BITS-1:0];
  assign len      = head_data[2*POS_BITS-1:POS_BITS];
  assign load     = head_valid && (!out_valid || out_ready);
  assign emit_gap = head_ctl.has_gap && !phase;
  assign pop      = load && !(emit_gap && head_ctl.has_end);

  assign mirror = (head_ctl.kind == KIND_TGT) ? POS_BITS'(tgt_len) : POS_BITS'(ref_len);
  assign pos    = reverse ? mirror - base : base;

  always_comb begin
    if (emit_gap) begin
      beat_kind   = head_ctl.kind;
      beat_pos    = OUT_W'(pos);
      beat_len    = OUT_W'(len);
      beat_status = ST_OK;
      beat_last   = !head_ctl.has_end;
    end else begin
      beat_kind   = KIND_END;
      beat_pos    = '0;
      beat_len    = '0;
      beat_status = head_ctl.status;
      beat_last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= {OUT_PAD_W'(0), head_ctl.clip, beat_status, beat_len, beat_pos};
      out_kind <= beat_kind;
      out_last <= beat_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= !pop;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sim/cigar_gap_walker_unit_tb.sv
// ----------------------------------------------------------------------------
// cigar_gap_walker_unit_tb
// Self-checking bench for the CIGAR gap walker.
// ----------------------------------------------------------------------------
// Feeds CIGAR text one character per beat and mirrors the walker in a local
// predictor. The predictor tracks the query and target counters, the length
// accumulator and the error and clip flags. Every character accepted on the
// slave stream is run through the predictor, which queues the gap and end
// status records it must cause. A monitor pops one record per master beat and
// compares every field. Stimulus is a short directed walk first. Register
// extremes come next, then random walks. Most random walks are well formed,
// some are retuned so the spans match, and the rest are damaged or plain
// noise. Both streams stall at random, except during one calm phase.
// ----------------------------------------------------------------------------
`default_nettype none

module cigar_gap_walker_unit_tb;
  import cgw_pkg::*;

  localparam int QUIET_LIMIT = 3000;  // cycles with no beat anywhere
  localparam int SETTLE_CYC  = 4;     // front end plus output register

  // one expected record on the master stream
  typedef struct packed {
    kind_t       kind;
    logic [31:0] pos;
    logic [31:0] len;
    status_t     status;
    logic        clip;
    logic        last;
  } gap_record_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [1:0]             m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  cigar_gap_walker_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow registers and walk state of the predictor
  logic        shadow_reverse;
  logic [31:0] shadow_ref_len;
  logic [31:0] shadow_span_start;
  logic [31:0] shadow_span_end;
  logic [31:0] shadow_tgt_len;

  logic [31:0] walk_query;
  logic [31:0] walk_target;
  logic [31:0] walk_length;
  logic        walk_digits;
  logic        walk_error;
  logic        walk_clip;

  gap_record_t pending_records[$];
  logic [7:0]  cigar_text[$];
  int          mismatches = 0;
  int          symbols_sent = 0;
  bit          calm = 1'b0;  // no stalls on either stream while set

  function automatic void clear_walk();
    walk_query  = '0;
    walk_target = '0;
    walk_length = '0;
    walk_digits = 1'b0;
    walk_error  = 1'b0;
    walk_clip   = 1'b0;
  endfunction

  function automatic void store_register(cfg_idx_t idx, logic [31:0] val);
    case (idx)
      CFG_REVERSE:    shadow_reverse    = val[0];
      CFG_REF_LEN:    shadow_ref_len    = val;
      CFG_SPAN_START: shadow_span_start = val;
      CFG_SPAN_END:   shadow_span_end   = val;
      CFG_TGT_LEN:    shadow_tgt_len    = val;
      default: ;
    endcase
  endfunction

  // Advance the predicted walk by one character and queue the records it
  // must produce: a gap record first, then the end status on a final beat.
  function automatic void walk_symbol(logic [7:0] sym, logic fin);
    gap_record_t rec;
    logic        has_gap;
    logic [63:0] grown;
    logic [31:0] len;
    logic [31:0] ref_pos;
    has_gap    = 1'b0;
    rec.kind   = KIND_END;
    rec.pos    = '0;
    rec.len    = '0;
    rec.status = ST_OK;
    rec.clip   = 1'b0;
    rec.last   = 1'b0;
    if (!walk_error) begin
      if (sym >= CH_0 && sym <= CH_9) begin
        // saturate rather than wrap on long digit runs
        grown = {32'd0, walk_length} * 64'd10 + {56'd0, sym - CH_0};
        walk_length = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
        walk_digits = 1'b1;
      end else if (!walk_digits) begin
        walk_error = 1'b1;
      end else begin
        len = walk_length;
        case (sym)
          CH_M, CH_X, CH_EQ: begin
            walk_query  = walk_query + len;
            walk_target = walk_target + len;
          end
          CH_P, CH_H: ;
          CH_S: begin
            walk_query = walk_query + len;
            walk_clip  = 1'b1;
          end
          CH_I: begin
            has_gap  = 1'b1;
            rec.kind = KIND_TGT;
            rec.len  = len;
            rec.pos  = shadow_reverse ? shadow_tgt_len - walk_target : walk_target;
            walk_query = walk_query + len;
          end
          CH_D, CH_N: begin
            has_gap  = 1'b1;
            rec.kind = (sym == CH_D) ? KIND_DEL : KIND_SKIP;
            rec.len  = len;
            // offset into the reference, mirrored on the reverse strand
            ref_pos = shadow_reverse ? shadow_ref_len - shadow_span_end
                                     : shadow_span_start;
            ref_pos = ref_pos + walk_query;
            if (shadow_reverse) ref_pos = shadow_ref_len - ref_pos;
            rec.pos = ref_pos;
            walk_target = walk_target + len;
          end
          default: walk_error = 1'b1;
        endcase
        walk_length = '0;
        walk_digits = 1'b0;
      end
    end
    if (has_gap) begin
      rec.clip = walk_clip;
      rec.last = !fin;
      pending_records.push_back(rec);
    end
    if (fin) begin
      rec.kind = KIND_END;
      rec.pos  = '0;
      rec.len  = '0;
      rec.clip = walk_clip;
      rec.last = 1'b1;
      if (walk_error || walk_digits)
        rec.status = ST_SYNTAX;
      else if (walk_target != shadow_tgt_len)
        rec.status = ST_TGT;
      else if (walk_query != shadow_span_end - shadow_span_start)
        rec.status = ST_REF;
      else
        rec.status = ST_OK;
      pending_records.push_back(rec);
      clear_walk();
    end
  endfunction

  // ------------------------------------------------------------------------
  // Record monitor: compare each master beat with the oldest expectation
  // ------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : record_monitor
    gap_record_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record, expected none actual kind %0d tdata %0h",
                 $time, m_tuser, m_tdata);
        mismatches++;
      end else begin
        want = pending_records.pop_front();
        check_field("record_kind",  want.kind,   m_tuser);
        check_field("gap_position", want.pos,    m_tdata[31:0]);
        check_field("gap_length",   want.len,    m_tdata[63:32]);
        check_field("end_status",   want.status, m_tdata[65:64]);
        check_field("clip_warning", want.clip,   m_tdata[66]);
        check_field("last_of_run",  want.last,   m_tlast);
      end
    end
  end

  // Receiver: stall about a third of the cycles unless the bench is calm
  always @(negedge clk) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
  end

  // Watchdog: end the run when no beat moves on any channel for too long
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // Shared drivers
  // ------------------------------------------------------------------------

  // Send one character; idle first at random unless the bench is calm.
  task automatic send_symbol(logic [7:0] sym, logic fin);
    int gaps;
    gaps = 0;
    @(negedge clk);
    while (!calm && gaps < 8 && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      gaps++;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sym;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    walk_symbol(sym, fin);
    symbols_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < cigar_text.size(); i++)
      send_symbol(cigar_text[i], i == cigar_text.size() - 1);
  endtask

  task automatic load_text(string s);
    cigar_text.delete();
    for (int i = 0; i < s.len(); i++) cigar_text.push_back(s[i]);
  endtask

  // Hold the sender until every queued record is out, then let the
  // pipeline empty so no character is still in flight.
  task automatic drain_walks();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Register write on the configuration channel; only called while idle.
  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    store_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    // leave a short idle gap between writes
    repeat (2) @(posedge clk);
  endtask

  task automatic write_all(logic rev, logic [31:0] ref_len, logic [31:0] start,
                           logic [31:0] stop, logic [31:0] tgt_len);
    write_reg(CFG_REVERSE,    {31'd0, rev});
    write_reg(CFG_REF_LEN,    ref_len);
    write_reg(CFG_SPAN_START, start);
    write_reg(CFG_SPAN_END,   stop);
    write_reg(CFG_TGT_LEN,    tgt_len);
  endtask

  // ------------------------------------------------------------------------
  // Random walk builders
  // ------------------------------------------------------------------------
  function automatic logic [31:0] pick_word();
    case ($urandom_range(3))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(8))
      0:       return CH_M;
      1:       return CH_X;
      2:       return CH_EQ;
      3:       return CH_I;
      4:       return CH_D;
      5:       return CH_N;
      6:       return CH_S;
      7:       return CH_P;
      default: return CH_H;
    endcase
  endfunction

  // Append a decimal length; mostly short, now and then past saturation.
  function automatic logic [31:0] append_length();
    int          digits;
    int          roll;
    logic [63:0] value;
    logic [7:0]  d;
    roll   = $urandom_range(99);
    digits = (roll < 80) ? $urandom_range(1, 2) :
             (roll < 96) ? $urandom_range(3, 9) : $urandom_range(10, 12);
    value  = '0;
    for (int i = 0; i < digits; i++) begin
      d = $urandom_range(9);
      cigar_text.push_back(CH_0 + d);
      value = value * 10 + d;
      if (value > 64'hFFFF_FFFF) value = 64'hFFFF_FFFF;
    end
    return value[31:0];
  endfunction

  // Build a well-formed walk and return the query and target spans it covers.
  task automatic build_walk(int ops, output logic [31:0] qsum,
                            output logic [31:0] tsum);
    logic [31:0] len;
    logic [7:0]  op;
    cigar_text.delete();
    qsum = '0;
    tsum = '0;
    for (int k = 0; k < ops; k++) begin
      len = append_length();
      op  = pick_op();
      cigar_text.push_back(op);
      case (op)
        CH_M, CH_X, CH_EQ: begin
          qsum = qsum + len;
          tsum = tsum + len;
        end
        CH_I, CH_S: qsum = qsum + len;
        CH_D, CH_N: tsum = tsum + len;
        default: ;
      endcase
    end
  endtask

  // One random walk: well formed, retuned to match, damaged, or noise.
  task automatic run_walk();
    logic [31:0] qsum;
    logic [31:0] tsum;
    logic [31:0] start;
    int          roll;
    int          ops;
    int          spot;
    roll = $urandom_range(99);
    ops  = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    if (roll < 92) build_walk(ops, qsum, tsum);
    if (roll < 15) begin
      // retune the spans so the end check passes, or misses by one base
      drain_walks();
      start = pick_word();
      write_reg(CFG_SPAN_START, start);
      write_reg(CFG_SPAN_END, start + qsum + ($urandom_range(3) == 0));
      write_reg(CFG_TGT_LEN, tsum + ($urandom_range(5) == 0));
    end else if (roll >= 80 && roll < 92) begin
      spot = $urandom_range(cigar_text.size() - 1);
      case ($urandom_range(3))
        0: cigar_text.insert(spot, $urandom_range(255));  // stray byte
        1: cigar_text.insert(spot, pick_op());            // letter, maybe no digits
        2: void'(cigar_text.pop_back());                  // digits left pending
        default: cigar_text.push_back(CH_0 + $urandom_range(9));
      endcase
    end else if (roll >= 92) begin
      cigar_text.delete();
      repeat ($urandom_range(1, 6)) cigar_text.push_back($urandom_range(255));
    end
    send_text();
    if ($urandom_range(99) < 3) drain_walks();
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Every operation, zero lengths, a final gap letter, a letter with no
  // digits, an unknown byte after digits, ignored bytes after an error and
  // digits pending at the end.
  task automatic test_directed();
    write_all(1'b0, 32'd1000, 32'd100, 32'd119, 32'd9);
    load_text("3M0I2D1N4S1=2X1P1H9I");
    send_text();
    load_text("I");
    send_text();
    cigar_text.delete();
    cigar_text.push_back(CH_1_BYTE());
    cigar_text.push_back(8'hFF);
    cigar_text.push_back(8'h00);
    send_text();
    load_text("2M7");
    send_text();
  endtask

  function automatic logic [7:0] CH_1_BYTE();
    return CH_0 + 8'd1;
  endfunction

  // Registers at their extremes, both strands.
  task automatic test_register_extremes();
    drain_walks();
    write_all(1'b1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (5) run_walk();
    drain_walks();
    write_all(1'b1, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
    repeat (5) run_walk();
    drain_walks();
    write_all(1'b0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    repeat (5) run_walk();
  endtask

  // Random phases with fresh registers; the third phase runs without stalls.
  task automatic test_random_walks(int budget);
    int phase;
    phase = 0;
    while (symbols_sent < budget) begin
      drain_walks();
      calm = (phase == 2);
      write_all($urandom_range(1), pick_word(), pick_word(), pick_word(), pick_word());
      for (int w = 0; w < 20 && symbols_sent < budget; w++) run_walk();
      phase++;
    end
    calm = 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_REVERSE;
    cfg_data  = '0;
    shadow_reverse    = 1'b0;
    shadow_ref_len    = '0;
    shadow_span_start = '0;
    shadow_span_end   = '0;
    shadow_tgt_len    = '0;
    clear_walk();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_register_extremes();
    test_random_walks(1900);

    // wait out the last records, then the pipeline
    drain_walks();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
